// ===== rtl/core/seven_segment_two_digit_mux_macros.svh =====
// Assertion macros used by the display driver checker.
`ifndef SEVEN_SEGMENT_TWO_DIGIT_MUX_MACROS_SVH
`define SEVEN_SEGMENT_TWO_DIGIT_MUX_MACROS_SVH

// Property checked at every clock edge outside reset.
`define SSDMUX_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ssdmux assertion failed");

// Property checked at every clock edge, reset included.
`define SSDMUX_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("ssdmux assertion failed");

`endif

// ===== rtl/core/ssdmux_pkg.sv =====
// Shared types, constants and glyph table of the two-digit display driver.
package ssdmux_pkg;

  // Word opcodes; the unused code is ignored
  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_SET_MAIN = 2'd1,
    OP_SET_ALT  = 2'd2
  } op_e;

  localparam int unsigned GlyphCount = 24;

  localparam logic [6:0] BLANK_PATTERN    = 7'h7f;
  localparam logic [7:0] DURATION_FOREVER = 8'hff;
  localparam logic [7:0] DECREMENT_POINT  = 8'h80;

  // Pattern store entries
  localparam logic [1:0] ENTRY_MAIN_LOW  = 2'd0;
  localparam logic [1:0] ENTRY_MAIN_HIGH = 2'd1;
  localparam logic [1:0] ENTRY_ALT_LOW   = 2'd2;
  localparam logic [1:0] ENTRY_ALT_HIGH  = 2'd3;

  // Active-low segment patterns: hex digits, then dash, P, blank, U, r, c, n, o
  localparam logic [6:0] GLYPH_TABLE [GlyphCount] = '{
    7'd8,   7'd94, 7'd34,  7'd66, 7'd84, 7'd65, 7'd1,  7'd90,
    7'd0,   7'd64, 7'd16,  7'd5,  7'd41, 7'd6,  7'd33, 7'd49,
    7'd119, 7'd48, 7'd127, 7'd12, 7'd55, 7'd39, 7'd23, 7'd7
  };

  // Codes past the table show blank
  function automatic logic [6:0] glyph_pattern(logic [4:0] code);
    logic [6:0] pat;
    pat = BLANK_PATTERN;
    if (32'(code) < GlyphCount) begin
      pat = GLYPH_TABLE[code];
    end
    return pat;
  endfunction

endpackage

// ===== rtl/core/ssdmux_decode.sv =====
// Glyph code to active-low segment pattern decoder.
module ssdmux_decode (
  input  logic [4:0] code_i,
  output logic [6:0] pattern_o
);
  import ssdmux_pkg::*;

  // table lookup with blank for unknown codes
  assign pattern_o = glyph_pattern(code_i);

endmodule

// ===== rtl/core/seven_segment_two_digit_mux.sv =====
// Two-digit multiplexed seven-segment display driver, top level.
//
//  channel | handshake               | word
//  --------+-------------------------+------------------------------------------
//  in      | in_valid_i / in_stall_o | op, glyph_high, glyph_low, cancel, duration
//  out     | out_valid_o/ out_stall_i| segments_n, right_digit_select, count
//
// One word per cycle while the input is not stalled: a word is held in the input
// register, and a tick is then registered into the output register.
// Set words update the pattern store and produce no output word.
// Reset clears the count and the alternate time and blanks all four patterns.
// A tick waits in the input register while the output word is stalled;
// the input stalls only then.
module seven_segment_two_digit_mux (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] op_i,
  input  logic [4:0] glyph_high_i,
  input  logic [4:0] glyph_low_i,
  input  logic       cancel_alternate_i,
  input  logic [7:0] alt_duration_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [6:0] segments_n_o,
  output logic       right_digit_select_o,
  output logic [7:0] refresh_count_o
);
  import ssdmux_pkg::*;

  // input register
  logic       in_valid_q, in_valid_d;
  logic [1:0] op_q;
  logic [4:0] glyph_high_q, glyph_low_q;
  logic       cancel_q;
  logic [7:0] duration_q;

  // state
  logic [7:0] tick_cnt_q, tick_cnt_d;
  logic [7:0] alt_rem_q, alt_rem_d;
  logic [6:0] store_q [4];
  logic [6:0] store_d [4];

  // output register
  logic       out_valid_q, out_valid_d;
  logic [6:0] seg_q, seg_d;
  logic       rsel_q, rsel_d;
  logic [7:0] cnt_out_q, cnt_out_d;

  logic       in_accept, out_free, is_tick, advance;
  logic [7:0] cnt_inc;
  logic [1:0] pick;
  logic [6:0] pat_high, pat_low;

  // glyph decoders on the held word
  ssdmux_decode u_dec_high (.code_i(glyph_high_q), .pattern_o(pat_high));
  ssdmux_decode u_dec_low  (.code_i(glyph_low_q),  .pattern_o(pat_low));

  // handshake
  assign out_free   = !out_valid_q || !out_stall_i;
  assign is_tick    = (op_q == OP_TICK);
  assign advance    = in_valid_q && (!is_tick || out_free);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign cnt_inc = 8'(tick_cnt_q + 8'd1);
  assign pick    = {alt_rem_q != 8'd0, cnt_inc[0]};

  // word processing
  always_comb begin
    tick_cnt_d  = tick_cnt_q;
    alt_rem_d   = alt_rem_q;
    store_d     = store_q;
    seg_d       = seg_q;
    rsel_d      = rsel_q;
    cnt_out_d   = cnt_out_q;
    out_valid_d = out_valid_q && out_stall_i;
    in_valid_d  = in_accept || (in_valid_q && !advance);
    if (advance) begin
      unique case (op_q)
        OP_TICK: begin
          tick_cnt_d  = cnt_inc;
          seg_d       = store_q[pick];
          rsel_d      = !cnt_inc[0];
          cnt_out_d   = cnt_inc;
          out_valid_d = 1'b1;
          if (alt_rem_q != 8'd0 && alt_rem_q != DURATION_FOREVER &&
              cnt_inc == DECREMENT_POINT) begin
            alt_rem_d = 8'(alt_rem_q - 8'd1);
          end
        end
        OP_SET_MAIN: begin
          store_d[ENTRY_MAIN_LOW]  = pat_low;
          store_d[ENTRY_MAIN_HIGH] = pat_high;
          if (cancel_q) begin
            alt_rem_d = 8'd0;
          end
        end
        OP_SET_ALT: begin
          store_d[ENTRY_ALT_LOW]  = pat_low;
          store_d[ENTRY_ALT_HIGH] = pat_high;
          alt_rem_d               = duration_q;
        end
        default: begin
        end
      endcase
    end
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      tick_cnt_q  <= 8'd0;
      alt_rem_q   <= 8'd0;
      for (int i = 0; i < 4; i++) begin
        store_q[i] <= BLANK_PATTERN;
      end
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      tick_cnt_q  <= tick_cnt_d;
      alt_rem_q   <= alt_rem_d;
      store_q     <= store_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q         <= op_i;
      glyph_high_q <= glyph_high_i;
      glyph_low_q  <= glyph_low_i;
      cancel_q     <= cancel_alternate_i;
      duration_q   <= alt_duration_i;
    end
    seg_q     <= seg_d;
    rsel_q    <= rsel_d;
    cnt_out_q <= cnt_out_d;
  end

  assign out_valid_o          = out_valid_q;
  assign segments_n_o         = seg_q;
  assign right_digit_select_o = rsel_q;
  assign refresh_count_o      = cnt_out_q;

endmodule

// ===== rtl/core/ssdmux_chk.sv =====
// Port-level checker for the display driver, bound to the top level.
`include "seven_segment_two_digit_mux_macros.svh"

module ssdmux_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [1:0] op_i,
  input logic [4:0] glyph_high_i,
  input logic [4:0] glyph_low_i,
  input logic       cancel_alternate_i,
  input logic [7:0] alt_duration_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [6:0] segments_n_o,
  input logic       right_digit_select_o,
  input logic [7:0] refresh_count_o
);

  logic        out_held, out_take, sel_ok;
  logic [15:0] out_word;
  logic [7:0]  cnt_up;

  // output channel views
  assign out_held = out_valid_o && out_stall_i;
  assign out_take = out_valid_o && !out_stall_i;
  assign out_word = {segments_n_o, right_digit_select_o, refresh_count_o};
  assign cnt_up   = 8'(refresh_count_o + 8'd1);
  assign sel_ok   = right_digit_select_o != refresh_count_o[0];

  // stalled output word holds
  `SSDMUX_ASSERT(a_out_hold, clk_i, rst_ni, out_held |=> out_valid_o && $stable(out_word))

  // digit select follows count parity
  `SSDMUX_ASSERT_ALWAYS(a_digit_parity, clk_i, !out_valid_o || sel_ok)

  // back-to-back output words carry consecutive counts
  `SSDMUX_ASSERT(a_cnt_step, clk_i, rst_ni, out_take ##1 out_valid_o |-> refresh_count_o == $past(cnt_up))

  // input stalls only behind a stalled output word
  `SSDMUX_ASSERT_ALWAYS(a_stall_cause, clk_i, !in_stall_o || out_held)

endmodule

bind seven_segment_two_digit_mux ssdmux_chk u_ssdmux_chk (.*);
